>>> sv/arc_ring_vertex_generator_defines.svh
// Assertion macros shared by the arc ring vertex generator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ARC_RING_VERTEX_GENERATOR_DEFINES_SVH
`define ARC_RING_VERTEX_GENERATOR_DEFINES_SVH

// same-cycle implication
`define ARVG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("arvg: same-cycle check failed");

// next-cycle implication
`define ARVG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("arvg: next-cycle check failed");

`endif

>>> sv/arvg_pkg.sv
// Package for the arc ring vertex generator: widths, register codes,
// pipeline control type and the CORDIC arctangent table. No dependencies.
package arvg_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int MAX_SEGMENTS      = 1024;
	localparam int DIV_STEPS         = 32;
	localparam int DEN_W             = 26;
	localparam int CW                = 33;
	localparam int DEG_FULL_TURN     = 23040;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic [2:0] REG_SEGMENT_COUNT = 3'd0;
	localparam logic [2:0] REG_OFFSET        = 3'd1;
	localparam logic [2:0] REG_SWEEP         = 3'd2;
	localparam logic [2:0] REG_INNER_RADIUS  = 3'd3;
	localparam logic [2:0] REG_THICKNESS     = 3'd4;
	localparam logic [2:0] REG_CENTRE_X      = 3'd5;
	localparam logic [2:0] REG_CENTRE_Y      = 3'd6;

	typedef struct packed {
		logic vld;
		logic oor;
	} ctl_t;

	function automatic logic signed [CW-1:0] atan_phase(input int k);
		logic signed [CW-1:0] v;
		case (k)
			0:  v = 33'sd536870912;
			1:  v = 33'sd316933406;
			2:  v = 33'sd167458907;
			3:  v = 33'sd85004756;
			4:  v = 33'sd42667331;
			5:  v = 33'sd21354465;
			6:  v = 33'sd10679838;
			7:  v = 33'sd5340245;
			8:  v = 33'sd2670163;
			9:  v = 33'sd1335087;
			10: v = 33'sd667544;
			11: v = 33'sd333772;
			12: v = 33'sd166886;
			13: v = 33'sd83443;
			14: v = 33'sd41722;
			15: v = 33'sd20861;
			16: v = 33'sd10430;
			17: v = 33'sd5215;
			18: v = 33'sd2608;
			19: v = 33'sd1304;
			20: v = 33'sd652;
			21: v = 33'sd326;
			22: v = 33'sd163;
			23: v = 33'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> sv/arvg_phase.sv
// Angle-to-phase pipeline: angle numerator, modulo reduction and a
// one-bit-per-stage restoring divider. Depends on arvg_pkg.
module arvg_phase (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_vld,
	input  logic [9:0]               segment_index,
	input  logic [10:0]              segment_count,
	input  logic signed [15:0]       offset_degrees,
	input  logic signed [15:0]       sweep_degrees,
	output arvg_pkg::ctl_t           ctl_o,
	output logic [31:0]              phase_o
);
	import arvg_pkg::*;

	logic [DEN_W-1:0]   den;
	logic [DEN_W+1:0]   den3;
	ctl_t               ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [27:0] pa_s1, pb_s1;
	logic signed [28:0] num_s2;
	logic [DEN_W+1:0]   t_s3;
	logic [DEN_W-1:0]   m_s4;
	logic signed [29:0] t_next;
	logic [DEN_W+1:0]   m_next;

	ctl_t             div_ctl_s [DIV_STEPS+1];
	logic [DEN_W-1:0] div_rem_s [DIV_STEPS+1];
	logic [31:0]      div_quo_s [DIV_STEPS+1];

	assign den  = DEN_W'(segment_count) * DEN_W'(DEG_FULL_TURN);
	assign den3 = (DEN_W+2)'(den) * (DEN_W+2)'(3);

	always_comb begin
		if (num_s2 < 0) begin
			t_next = 30'(num_s2) + $signed({2'b00, den3});
		end else begin
			t_next = 30'(num_s2);
		end
		if (t_s3 >= {1'b0, den, 1'b0}) begin
			m_next = t_s3 - {1'b0, den, 1'b0};
		end else if (t_s3 >= {2'b00, den}) begin
			m_next = t_s3 - {2'b00, den};
		end else begin
			m_next = t_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{vld: in_vld, oor: {1'b0, segment_index} >= segment_count};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s1  <= offset_degrees * $signed({1'b0, segment_count});
			pb_s1  <= $signed({1'b0, segment_index}) * sweep_degrees;
			num_s2 <= 29'(pa_s1) + 29'(pb_s1);
			t_s3   <= t_next[DEN_W+1:0];
			m_s4   <= ctl_s3.oor ? '0 : m_next[DEN_W-1:0];
		end
	end

	assign div_ctl_s[0] = ctl_s4;
	assign div_rem_s[0] = m_s4;
	assign div_quo_s[0] = '0;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [DEN_W:0] rem2;
		logic           ge;
		logic [DEN_W:0] diff;

		assign rem2 = {div_rem_s[k], 1'b0};
		assign ge   = rem2 >= {1'b0, den};
		assign diff = rem2 - {1'b0, den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_ctl_s[k+1] <= '0;
			end else if (adv) begin
				div_ctl_s[k+1] <= div_ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[k+1] <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
				div_quo_s[k+1] <= {div_quo_s[k][30:0], ge};
			end
		end
	end

	assign ctl_o   = div_ctl_s[DIV_STEPS];
	assign phase_o = div_quo_s[DIV_STEPS];

endmodule

>>> sv/arvg_cordic.sv
// Unrolled CORDIC pipeline: quadrant reduction, one rotation per stage,
// quadrant restore. Depends on arvg_pkg and the assertion macro header.
`include "arc_ring_vertex_generator_defines.svh"

module arvg_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  arvg_pkg::ctl_t     ctl_i,
	input  logic [31:0]        phase_i,
	output arvg_pkg::ctl_t     ctl_o,
	output logic signed [31:0] cos_o,
	output logic signed [31:0] sin_o
);
	import arvg_pkg::*;

	logic [1:0]  q_in;
	logic [31:0] r_in;

	ctl_t                 cr_ctl_s [CORDIC_ITERATIONS+1];
	logic [1:0]           cr_q_s   [CORDIC_ITERATIONS+1];
	logic signed [CW-1:0] cr_x_s   [CORDIC_ITERATIONS+1];
	logic signed [CW-1:0] cr_y_s   [CORDIC_ITERATIONS+1];
	logic signed [CW-1:0] cr_z_s   [CORDIC_ITERATIONS+1];

	ctl_t               ctl_rot_s;
	logic signed [31:0] cos_rot_s, sin_rot_s;
	logic signed [CW-1:0] xf, yf;

	assign q_in = phase_i[31:30] + {1'b0, phase_i[29]};
	assign r_in = phase_i - {q_in, 30'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_ctl_s[0] <= '0;
		end else if (adv) begin
			cr_ctl_s[0] <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_q_s[0] <= q_in;
			cr_x_s[0] <= CORDIC_GAIN;
			cr_y_s[0] <= '0;
			cr_z_s[0] <= CW'($signed(r_in));
		end
	end

	for (genvar k = 0; k < CORDIC_ITERATIONS; k++) begin : g_rot
		logic                 d;
		logic signed [CW-1:0] dx, dy, at;

		assign d  = !cr_z_s[k][CW-1];
		assign dx = cr_y_s[k] >>> k;
		assign dy = cr_x_s[k] >>> k;
		assign at = atan_phase(k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cr_ctl_s[k+1] <= '0;
			end else if (adv) begin
				cr_ctl_s[k+1] <= cr_ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cr_q_s[k+1] <= cr_q_s[k];
				cr_x_s[k+1] <= d ? cr_x_s[k] - dx : cr_x_s[k] + dx;
				cr_y_s[k+1] <= d ? cr_y_s[k] + dy : cr_y_s[k] - dy;
				cr_z_s[k+1] <= d ? cr_z_s[k] - at : cr_z_s[k] + at;
			end
		end
	end

	assign xf = cr_x_s[CORDIC_ITERATIONS];
	assign yf = cr_y_s[CORDIC_ITERATIONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_rot_s <= '0;
		end else if (adv) begin
			ctl_rot_s <= cr_ctl_s[CORDIC_ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (cr_q_s[CORDIC_ITERATIONS])
				2'd0: begin
					cos_rot_s <= 32'(xf);
					sin_rot_s <= 32'(yf);
				end
				2'd1: begin
					cos_rot_s <= 32'(-yf);
					sin_rot_s <= 32'(xf);
				end
				2'd2: begin
					cos_rot_s <= 32'(-xf);
					sin_rot_s <= 32'(-yf);
				end
				default: begin
					cos_rot_s <= 32'(yf);
					sin_rot_s <= 32'(-xf);
				end
			endcase
		end
	end

	assign ctl_o = ctl_rot_s;
	assign cos_o = cos_rot_s;
	assign sin_o = sin_rot_s;

	`ARVG_ASSERT_NXT(a_first_stage_moves, clk, arst_n, adv && cr_ctl_s[0].vld, cr_ctl_s[1].vld)
	`ARVG_ASSERT_NXT(a_hold_on_stall, clk, arst_n, !adv, $stable(ctl_rot_s) && $stable(cos_rot_s))
	`ARVG_ASSERT_NXT(a_bubble_moves, clk, arst_n, adv && !ctl_i.vld, !cr_ctl_s[0].vld)

endmodule

>>> sv/arvg_coord.sv
// Coordinate back end: radius times cosine and sine, rounding, centre
// offset and saturation to Q12.8. Depends on arvg_pkg.
module arvg_coord (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  arvg_pkg::ctl_t     ctl_i,
	input  logic signed [31:0] cos_i,
	input  logic signed [31:0] sin_i,
	input  logic [15:0]        inner_radius,
	input  logic [15:0]        thickness,
	input  logic signed [15:0] centre_x,
	input  logic signed [15:0] centre_y,
	output arvg_pkg::ctl_t     ctl_o,
	output logic signed [19:0] inner_x,
	output logic signed [19:0] inner_y,
	output logic signed [19:0] outer_x,
	output logic signed [19:0] outer_y
);
	import arvg_pkg::*;

	logic [16:0]        ro;
	ctl_t               ctl_m_s1, ctl_o_s2;
	logic signed [49:0] pix_s1, piy_s1, pox_s1, poy_s1;
	logic signed [19:0] ix_s2, iy_s2, ox_s2, oy_s2;

	function automatic logic signed [19:0] place(input logic signed [15:0] c,
		input logic signed [49:0] p);
		logic signed [49:0] pr;
		logic signed [19:0] sh;
		logic signed [21:0] sum;
		pr  = p + 50'sd536870912;
		sh  = pr[49:30];
		sum = {{6{c[15]}}, c} + {{2{sh[19]}}, sh};
		if (sum > 22'sd524287) begin
			return 20'sd524287;
		end else if (sum < -22'sd524288) begin
			return -20'sd524288;
		end
		return sum[19:0];
	endfunction

	assign ro = {1'b0, inner_radius} + {1'b0, thickness};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_m_s1 <= '0;
			ctl_o_s2 <= '0;
		end else if (adv) begin
			ctl_m_s1 <= ctl_i;
			ctl_o_s2 <= ctl_m_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= $signed({2'b00, inner_radius}) * cos_i;
			piy_s1 <= $signed({2'b00, inner_radius}) * sin_i;
			pox_s1 <= $signed({1'b0, ro}) * cos_i;
			poy_s1 <= $signed({1'b0, ro}) * sin_i;
			ix_s2  <= ctl_m_s1.oor ? '0 : place(centre_x, pix_s1);
			iy_s2  <= ctl_m_s1.oor ? '0 : place(centre_y, piy_s1);
			ox_s2  <= ctl_m_s1.oor ? '0 : place(centre_x, pox_s1);
			oy_s2  <= ctl_m_s1.oor ? '0 : place(centre_y, poy_s1);
		end
	end

	assign ctl_o   = ctl_o_s2;
	assign inner_x = ix_s2;
	assign inner_y = iy_s2;
	assign outer_x = ox_s2;
	assign outer_y = oy_s2;

endmodule

>>> sv/arc_ring_vertex_generator.sv
// Top level of the arc ring vertex generator: APB register file, phase,
// CORDIC and coordinate pipelines. Depends on arvg_pkg and the arvg_* modules.
//
// Usage: program the seven registers over APB (byte address 4*i) while the
// block is idle, then stream segment indices on in_valid/in_stall. Each
// transaction yields one result on out_valid/out_stall carrying the inner
// and outer vertex (signed Q12.8, saturated) and index_out_of_range, which
// zeroes the coordinates when the index is not below segment_count.
// From acceptance to out_valid a transaction passes 4 angle stages, 32
// divider stages (one quotient bit each), 18 CORDIC stages and 2 coordinate
// stages. One transaction is accepted in each cycle that in_stall is low.
// The whole pipeline advances together; in_stall rises only while a result
// sits in the output register with out_stall high, and then every stage
// holds. Reset clears all valid bits and sets segment_count to 1 and the
// other registers to 0. pready is tied high.
module arc_ring_vertex_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [9:0]         segment_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [19:0] inner_x,
	output logic signed [19:0] inner_y,
	output logic signed [19:0] outer_x,
	output logic signed [19:0] outer_y,
	output logic               index_out_of_range
);
	import arvg_pkg::*;

	logic [10:0]        count_q;
	logic signed [15:0] offset_q, sweep_q, cx_q, cy_q;
	logic [15:0]        rin_q, thick_q;
	logic               adv;
	logic               wr;
	ctl_t               ph_ctl, cr_ctl, co_ctl;
	logic [31:0]        phase;
	logic signed [31:0] cosv, sinv;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign adv    = !(co_ctl.vld && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 11'd1;
			offset_q <= '0;
			sweep_q  <= '0;
			rin_q    <= '0;
			thick_q  <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
		end else if (wr) begin
			unique case (paddr[4:2])
				REG_SEGMENT_COUNT: count_q  <= pwdata[10:0];
				REG_OFFSET:        offset_q <= pwdata[15:0];
				REG_SWEEP:         sweep_q  <= pwdata[15:0];
				REG_INNER_RADIUS:  rin_q    <= pwdata[15:0];
				REG_THICKNESS:     thick_q  <= pwdata[15:0];
				REG_CENTRE_X:      cx_q     <= pwdata[15:0];
				REG_CENTRE_Y:      cy_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_SEGMENT_COUNT: prdata = {21'b0, count_q};
			REG_OFFSET:        prdata = {16'b0, offset_q};
			REG_SWEEP:         prdata = {16'b0, sweep_q};
			REG_INNER_RADIUS:  prdata = {16'b0, rin_q};
			REG_THICKNESS:     prdata = {16'b0, thick_q};
			REG_CENTRE_X:      prdata = {16'b0, cx_q};
			REG_CENTRE_Y:      prdata = {16'b0, cy_q};
			default:           prdata = '0;
		endcase
	end

	arvg_phase u_phase (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.in_vld         (in_valid),
		.segment_index  (segment_index),
		.segment_count  (count_q),
		.offset_degrees (offset_q),
		.sweep_degrees  (sweep_q),
		.ctl_o          (ph_ctl),
		.phase_o        (phase)
	);

	arvg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_i   (ph_ctl),
		.phase_i (phase),
		.ctl_o   (cr_ctl),
		.cos_o   (cosv),
		.sin_o   (sinv)
	);

	arvg_coord u_coord (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.ctl_i        (cr_ctl),
		.cos_i        (cosv),
		.sin_i        (sinv),
		.inner_radius (rin_q),
		.thickness    (thick_q),
		.centre_x     (cx_q),
		.centre_y     (cy_q),
		.ctl_o        (co_ctl),
		.inner_x      (inner_x),
		.inner_y      (inner_y),
		.outer_x      (outer_x),
		.outer_y      (outer_y)
	);

	assign in_stall           = !adv;
	assign out_valid          = co_ctl.vld;
	assign index_out_of_range = co_ctl.oor;

endmodule
